### hdl/htic_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the hex text to I2C command parser.
package htic_pkg;

	// Bus commands as they leave the block.
	typedef enum logic [1:0] {
		OP_STOP  = 2'd0,
		OP_START = 2'd1,
		OP_WRITE = 2'd2
	} bus_op_t;

	// Parser phases.
	typedef enum logic [1:0] {
		PH_TOKEN   = 2'd0,
		PH_DATA_LO = 2'd1,
		PH_ADDR_HI = 2'd2,
		PH_ADDR_LO = 2'd3
	} phase_t;

	// Character codes.
	localparam logic [7:0] CH_OPEN    = 8'h5B;
	localparam logic [7:0] CH_CLOSE   = 8'h5D;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] OFS_UPPER  = 8'h37;
	localparam logic [7:0] OFS_LOWER  = 8'h57;

	// Commands one input item asks for, emitted in the order stop, start, write.
	typedef struct packed {
		logic       stop;
		logic       start;
		logic       write;
	} op_mask_t;

	typedef struct packed {
		op_mask_t   ops;
		logic [6:0] addr;
		logic [7:0] data;
	} job_t;

endpackage

### hdl/htic_in_if.sv
`timescale 1ns / 1ps
// Character input channel: valid/ready handshake with command and character payload.
interface htic_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] char_code;

	modport source (output valid, output command, output char_code, input ready);
	modport sink (input valid, input command, input char_code, output ready);
endinterface

### hdl/htic_out_if.sv
`timescale 1ns / 1ps
// Bus command output channel: valid/ready handshake with command payload.
interface htic_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] bus_op;
	logic [7:0] op_value;
	logic       last_of_run;

	modport source (output valid, output bus_op, output op_value, output last_of_run,
		input ready);
	modport sink (input valid, input bus_op, input op_value, input last_of_run,
		output ready);
endinterface

### hdl/htic_front.sv
`timescale 1ns / 1ps
// Front end: accepts characters, keeps the parser state and issues at most one job per item.
module htic_front (
	input  logic            clk,
	input  logic            arst_n,
	htic_in_if.sink         char_in,
	output logic            job_valid,
	output htic_pkg::job_t  job,
	input  logic            job_ready
);

	htic_pkg::phase_t phase_q, phase_n;
	logic [3:0]       nibble_q, nibble_n;
	logic [6:0]       addr_q, addr_n;
	logic             msg_open_q, msg_open_n;
	logic             bus_held_q, bus_held_n;

	logic             accept;
	logic             is_hex;
	logic             is_open;
	logic             is_close;
	logic [7:0]       diff;
	logic [3:0]       val;
	logic             send;
	logic [7:0]       send_byte;
	htic_pkg::job_t   job_c;

	assign char_in.ready = job_ready;
	assign accept        = char_in.valid && char_in.ready;

	always_comb begin
		is_hex = 1'b1;
		diff   = 8'd0;
		if (char_in.char_code inside {[htic_pkg::CH_DIGIT_0 : htic_pkg::CH_DIGIT_9]}) begin
			diff = char_in.char_code - htic_pkg::CH_DIGIT_0;
		end else if (char_in.char_code inside
				{[htic_pkg::CH_UPPER_A : htic_pkg::CH_UPPER_F]}) begin
			diff = char_in.char_code - htic_pkg::OFS_UPPER;
		end else if (char_in.char_code inside
				{[htic_pkg::CH_LOWER_A : htic_pkg::CH_LOWER_F]}) begin
			diff = char_in.char_code - htic_pkg::OFS_LOWER;
		end else begin
			is_hex = 1'b0;
		end
		// A bracket used as a nibble counts as zero.
		val      = diff[3:0];
		is_open  = (char_in.char_code == htic_pkg::CH_OPEN);
		is_close = (char_in.char_code == htic_pkg::CH_CLOSE);
	end

	always_comb begin
		phase_n    = phase_q;
		nibble_n   = nibble_q;
		addr_n     = addr_q;
		msg_open_n = msg_open_q;
		bus_held_n = bus_held_q;
		send       = 1'b0;
		send_byte  = 8'd0;
		job_c      = '0;
		job_c.addr = addr_q;

		if (char_in.command) begin
			case (phase_q)
				htic_pkg::PH_DATA_LO: begin
					send      = 1'b1;
					send_byte = {nibble_q, 4'd0};
				end
				htic_pkg::PH_ADDR_HI: addr_n = 7'd0;
				htic_pkg::PH_ADDR_LO: addr_n = {nibble_q, 3'd0};
				default: ;
			endcase
			// Any open message is left without a stop; the bus stays held.
			if (msg_open_q || send) begin
				bus_held_n = 1'b1;
			end
			msg_open_n = 1'b0;
			phase_n    = htic_pkg::PH_TOKEN;
			nibble_n   = 4'd0;
		end else if (is_hex || is_open || is_close) begin
			case (phase_q)
				htic_pkg::PH_TOKEN: begin
					if (is_open) begin
						phase_n = htic_pkg::PH_ADDR_HI;
					end else if (is_close) begin
						job_c.ops.stop = 1'b1;
						msg_open_n     = 1'b0;
						bus_held_n     = 1'b0;
					end else begin
						nibble_n = val;
						phase_n  = htic_pkg::PH_DATA_LO;
					end
				end
				htic_pkg::PH_DATA_LO: begin
					send      = 1'b1;
					send_byte = {nibble_q, val};
					phase_n   = htic_pkg::PH_TOKEN;
				end
				htic_pkg::PH_ADDR_HI: begin
					nibble_n = val;
					phase_n  = htic_pkg::PH_ADDR_LO;
				end
				htic_pkg::PH_ADDR_LO: begin
					addr_n  = {nibble_q, val[3:1]};
					phase_n = htic_pkg::PH_TOKEN;
				end
				default: ;
			endcase
		end

		if (send) begin
			job_c.ops.write = 1'b1;
			job_c.data      = send_byte;
			if (!msg_open_q) begin
				job_c.ops.start = 1'b1;
				job_c.ops.stop  = bus_held_q;
				if (!char_in.command) begin
					msg_open_n = 1'b1;
					bus_held_n = 1'b0;
				end
			end
		end
	end

	assign job       = job_c;
	assign job_valid = accept && (job_c.ops != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= htic_pkg::PH_TOKEN;
			nibble_q   <= 4'd0;
			addr_q     <= 7'd0;
			msg_open_q <= 1'b0;
			bus_held_q <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_n;
			nibble_q   <= nibble_n;
			addr_q     <= addr_n;
			msg_open_q <= msg_open_n;
			bus_held_q <= bus_held_n;
		end
	end

endmodule

### hdl/htic_fifo.sv
`timescale 1ns / 1ps
// Short job queue between the parser front end and the command sequencer.
module htic_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  htic_pkg::job_t  push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output htic_pkg::job_t  pop_data
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	htic_pkg::job_t   entry_q [DEPTH];
	logic [IDX_W-1:0] wr_idx_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_idx_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_idx_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_idx_q <= (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
			end
			if (pop) begin
				rd_idx_q <= (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/htic_back.sv
`timescale 1ns / 1ps
// Back end: serializes each queued job into bus commands through an output register.
module htic_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  htic_pkg::job_t  job,
	htic_out_if.source      cmd_out
);

	htic_pkg::op_mask_t done_q;
	htic_pkg::op_mask_t pend;
	htic_pkg::op_mask_t sel;
	logic               advance;
	logic               last;
	htic_pkg::bus_op_t  op_c;
	logic [7:0]         value_c;

	logic               out_valid_q;
	htic_pkg::bus_op_t  out_op_q;
	logic [7:0]         out_value_q;
	logic               out_last_q;

	assign pend    = job.ops & ~done_q;
	assign advance = job_valid && (!out_valid_q || cmd_out.ready);

	always_comb begin
		sel     = '0;
		op_c    = htic_pkg::OP_WRITE;
		value_c = job.data;
		if (pend.stop) begin
			sel.stop = 1'b1;
			op_c     = htic_pkg::OP_STOP;
			value_c  = 8'd0;
		end else if (pend.start) begin
			sel.start = 1'b1;
			op_c      = htic_pkg::OP_START;
			value_c   = {1'b0, job.addr};
		end else begin
			sel.write = 1'b1;
		end
		last = ((pend & ~sel) == '0);
	end

	// The job leaves the queue with its last command.
	assign job_ready = advance && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				done_q      <= last ? '0 : (done_q | sel);
				out_valid_q <= 1'b1;
			end else if (cmd_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_op_q    <= op_c;
			out_value_q <= value_c;
			out_last_q  <= last;
		end
	end

	assign cmd_out.valid       = out_valid_q;
	assign cmd_out.bus_op      = out_op_q;
	assign cmd_out.op_value    = out_value_q;
	assign cmd_out.last_of_run = out_last_q;

`ifndef SYNTHESIS
	a_job_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> (pend != '0))
		else $error("queued job has no command left to emit");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last) |=> (done_q == '0))
		else $error("progress mask not cleared after the last command of a job");

	a_start_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_op_q == htic_pkg::OP_START)) |-> !out_last_q)
		else $error("start command marked as last of its run");

	a_write_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && sel.start) |=> (out_valid_q && pend.write))
		else $error("start command not followed by its data write");
`endif

endmodule

### hdl/hex_text_to_i2c_command_parser.sv
`timescale 1ns / 1ps
// Top level of the hex text to I2C command parser.
// The block reads characters and end-of-line marks and emits I2C master commands (stop, start
// for write with a 7-bit address, write data byte), with last_of_run set on the final command
// that one input item causes. The front end takes one character per cycle whenever the job
// queue has room and turns it into zero or one job; the back end sends one command per cycle,
// unless cmd_out.ready holds it, from the queue head through an output register. An item
// causes zero to three commands, so the sustained throughput is set by the single command
// sequencer. QUEUE_DEPTH jobs can wait between the two halves, so bursts of characters are
// taken while commands drain.
module hex_text_to_i2c_command_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	htic_in_if.sink    char_in,
	htic_out_if.source cmd_out
);

	logic           push_valid;
	logic           push_ready;
	htic_pkg::job_t push_job;
	logic           head_valid;
	logic           head_ready;
	htic_pkg::job_t head_job;

	htic_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (char_in),
		.job_valid (push_valid),
		.job       (push_job),
		.job_ready (push_ready)
	);

	htic_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_job),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop_data   (head_job)
	);

	htic_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (head_valid),
		.job_ready (head_ready),
		.job       (head_job),
		.cmd_out   (cmd_out)
	);

endmodule
